@@ hdl/tllt_pkg.sv @@
// Shared types, constants and per-item helper functions for the three-lane lap timer.
// Has no dependencies; it is used by the top level three_lane_lap_timer.
`default_nettype none

package tllt_pkg;

  // Lap store geometry and field widths.
  localparam int unsigned MAX_LAPS  = 5;
  localparam int unsigned LAP_W     = 3;
  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned NUM_PINS  = 5;

  // Pin positions in the debounce bank.
  localparam int unsigned PIN_START    = 0;
  localparam int unsigned PIN_RESET    = 1;
  localparam int unsigned PIN_SENSOR_A = 2;

  // Reset values and thresholds.
  localparam logic [15:0] STUCK_LIMIT_RESET = 16'd50;
  localparam logic [7:0]  DEBOUNCE_RESET    = 8'hFF;
  localparam logic [7:0]  DEBOUNCE_FIRE     = 8'h03;
  localparam logic [6:0]  CENTIS_MAX        = 7'd99;
  localparam logic [5:0]  SECONDS_MAX       = 6'd59;

  // One time value: minutes, seconds, centiseconds.
  typedef struct packed {
    logic [7:0] minutes;
    logic [5:0] seconds;
    logic [6:0] centis;
  } stamp_t;

  // Debouncer and stuck counter of one pin.
  typedef struct packed {
    logic [7:0]  shift;
    logic [15:0] count;
  } pin_state_t;

  // Outcome of sampling one pin.
  typedef struct packed {
    pin_state_t state;
    logic       stuck;
    logic       fire;
  } pin_result_t;

  // Sample one active-low pin. A pressed sample tests the counter against the
  // limit (at_least selects >= instead of >) before incrementing it.
  function automatic pin_result_t pin_step(pin_state_t cur, logic level, logic at_least,
                                           logic [15:0] limit);
    pin_result_t res;
    res.stuck = 1'b0;
    if (!level) begin
      res.stuck       = at_least ? (cur.count >= limit) : (cur.count > limit);
      res.state.count = cur.count + 16'd1;
      res.state.shift = res.stuck ? cur.shift : {cur.shift[6:0], 1'b1};
    end else begin
      res.state.count = '0;
      res.state.shift = {cur.shift[6:0], 1'b0};
    end
    res.fire = (res.state.shift == DEBOUNCE_FIRE);
    return res;
  endfunction

  // Advance a time value by one centisecond; minutes wrap at 256.
  function automatic stamp_t stamp_tick(stamp_t t);
    stamp_t n;
    n = t;
    if (t.centis >= CENTIS_MAX) begin
      n.centis = '0;
      if (t.seconds >= SECONDS_MAX) begin
        n.seconds = '0;
        n.minutes = t.minutes + 8'd1;
      end else begin
        n.seconds = t.seconds + 6'd1;
      end
    end else begin
      n.centis = t.centis + 7'd1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ hdl/three_lane_lap_timer.sv @@
// Top level of the three-lane lap timer: pin debouncing, run control, lap store.
// Depends on tllt_pkg for types, constants and the pin and time helpers.
//
//   Channel   Handshake            Beat contents
//   --------  -------------------  ------------------------------------------------
//   input     in_valid / in_stall  time_tick, five pin levels, query_lane, query_lap
//   output    out_valid/out_stall  run flag, lap counts, masks, time, queried record
//   config    stuck_limit_we       stuck_limit_wdata (16 bit)
//
// One beat is taken per cycle while in_stall is low; its whole update runs between
// the state registers and the result register, so the result appears the cycle
// after acceptance. The result register holds a waiting result; in_stall is raised
// only while that result is held by out_stall, otherwise a new beat is taken in the
// same cycle. rst is synchronous: it clears time, laps and the record store, sets
// the debouncers to all ones and the stuck limit to 50.
`default_nettype none

module three_lane_lap_timer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        time_tick,
  input  wire logic        start_stop_pin,
  input  wire logic        reset_pin,
  input  wire logic        sensor_a_pin,
  input  wire logic        sensor_b_pin,
  input  wire logic        sensor_c_pin,
  input  wire logic [1:0]  query_lane,
  input  wire logic [2:0]  query_lap,
  input  wire logic        stuck_limit_we,
  input  wire logic [15:0] stuck_limit_wdata,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             running,
  output logic [2:0]       lap_count_a,
  output logic [2:0]       lap_count_b,
  output logic [2:0]       lap_count_c,
  output logic [2:0]       capture_mask,
  output logic [4:0]       stuck_mask,
  output logic [7:0]       now_minutes,
  output logic [5:0]       now_seconds,
  output logic [6:0]       now_centis,
  output logic [7:0]       rec_minutes,
  output logic [5:0]       rec_seconds,
  output logic [6:0]       rec_centis
);

  localparam int unsigned LapW  = tllt_pkg::LAP_W;
  localparam int unsigned Lanes = tllt_pkg::NUM_LANES;
  localparam int unsigned Laps  = tllt_pkg::MAX_LAPS;

  // State registers.
  logic [15:0]          stuck_limit;
  logic                 run_flag;
  tllt_pkg::stamp_t     now;
  tllt_pkg::pin_state_t pin_st   [tllt_pkg::NUM_PINS];
  logic [LapW-1:0]      lap_cnt  [Lanes];
  tllt_pkg::stamp_t     rec      [Lanes][1:Laps];

  // Next values.
  logic                 run_next;
  tllt_pkg::stamp_t     now_next;
  tllt_pkg::pin_state_t pin_next [tllt_pkg::NUM_PINS];
  logic [LapW-1:0]      lap_next [Lanes];
  tllt_pkg::stamp_t     rec_next [Lanes][1:Laps];
  logic [2:0]           cap_next;
  logic [4:0]           stuck_next;
  tllt_pkg::stamp_t     rec_rd_next;

  logic accept;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Per-item update: buttons first, then lanes while running, then the tick.
  always_comb begin
    tllt_pkg::pin_result_t start_res;
    tllt_pkg::pin_result_t reset_res;
    tllt_pkg::pin_result_t sensor_res;
    logic [2:0]            sensor_pin;
    logic [2:0]            sensor_stuck;
    logic                  run_mid;
    logic                  clear_fire;
    tllt_pkg::stamp_t      now_base;
    logic [LapW-1:0]       lap_base;
    logic [LapW-1:0]       lap_new [Lanes];

    sensor_pin   = {sensor_c_pin, sensor_b_pin, sensor_a_pin};
    sensor_stuck = '0;

    // Start/stop button: stuck forces run on, a debounced press toggles it.
    start_res = tllt_pkg::pin_step(pin_st[tllt_pkg::PIN_START], start_stop_pin, 1'b0,
                                   stuck_limit);
    run_mid = run_flag;
    if (start_res.stuck) begin
      run_mid = 1'b1;
    end
    if (start_res.fire) begin
      run_mid = ~run_mid;
    end

    // Reset button: stuck forces run on, a debounced press clears time, laps and records.
    reset_res = tllt_pkg::pin_step(pin_st[tllt_pkg::PIN_RESET], reset_pin, 1'b0,
                                   stuck_limit);
    if (reset_res.stuck) begin
      run_mid = 1'b1;
    end
    clear_fire = reset_res.fire;

    pin_next[tllt_pkg::PIN_START] = start_res.state;
    pin_next[tllt_pkg::PIN_RESET] = reset_res.state;

    now_base = clear_fire ? '0 : now;

    // Lane sensors act only while running; lanes A and B use the >= test.
    for (int l = 0; l < Lanes; l++) begin
      sensor_res = tllt_pkg::pin_step(pin_st[tllt_pkg::PIN_SENSOR_A + l], sensor_pin[l],
                                      (l < 2), stuck_limit);
      pin_next[tllt_pkg::PIN_SENSOR_A + l] =
          run_mid ? sensor_res.state : pin_st[tllt_pkg::PIN_SENSOR_A + l];
      sensor_stuck[l] = run_mid & sensor_res.stuck;
      cap_next[l]     = run_mid & sensor_res.fire;

      lap_base    = clear_fire ? '0 : lap_cnt[l];
      lap_new[l]  = (lap_base < LapW'(Laps)) ? lap_base + LapW'(1) : LapW'(Laps);
      lap_next[l] = cap_next[l] ? lap_new[l] : lap_base;

      // A capture writes the current time into the lane's new lap slot.
      for (int s = 1; s <= Laps; s++) begin
        rec_next[l][s] = clear_fire ? '0 : rec[l][s];
        if (cap_next[l] && (lap_new[l] == LapW'(s))) begin
          rec_next[l][s] = now_base;
        end
      end
    end

    // A stuck sensor stops the watch.
    run_next   = run_mid & ~(|sensor_stuck);
    stuck_next = {sensor_stuck, reset_res.stuck, start_res.stuck};

    // Tick after pin handling.
    now_next = (time_tick && run_next) ? tllt_pkg::stamp_tick(now_base) : now_base;

    // Read back the queried slot as it stands after this item; slot 0 and out-of-range queries read zero.
    rec_rd_next = '0;
    if ((query_lane <= 2'(Lanes - 1)) && (query_lap != 3'd0) &&
        (query_lap <= 3'(Laps))) begin
      rec_rd_next = rec_next[query_lane][query_lap];
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stuck_limit <= tllt_pkg::STUCK_LIMIT_RESET;
    end else if (stuck_limit_we) begin
      stuck_limit <= stuck_limit_wdata;
    end
  end

  // State registers advance on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag <= 1'b0;
      now      <= '0;
      for (int p = 0; p < tllt_pkg::NUM_PINS; p++) begin
        pin_st[p].shift <= tllt_pkg::DEBOUNCE_RESET;
        pin_st[p].count <= '0;
      end
      for (int l = 0; l < Lanes; l++) begin
        lap_cnt[l] <= '0;
        for (int s = 1; s <= Laps; s++) begin
          rec[l][s] <= '0;
        end
      end
    end else if (accept) begin
      run_flag <= run_next;
      now      <= now_next;
      pin_st   <= pin_next;
      lap_cnt  <= lap_next;
      rec      <= rec_next;
    end
  end

  // Result valid flag: set on accept, cleared once the result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      running      <= run_next;
      lap_count_a  <= lap_next[0];
      lap_count_b  <= lap_next[1];
      lap_count_c  <= lap_next[2];
      capture_mask <= cap_next;
      stuck_mask   <= stuck_next;
      now_minutes  <= now_next.minutes;
      now_seconds  <= now_next.seconds;
      now_centis   <= now_next.centis;
      rec_minutes  <= rec_rd_next.minutes;
      rec_seconds  <= rec_rd_next.seconds;
      rec_centis   <= rec_rd_next.centis;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tllt_checker.sv @@
// Port-level checker for the three-lane lap timer, with its bind statement.
// Depends only on the ports of three_lane_lap_timer.
`default_nettype none

module tllt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] lap_count_a,
  input wire logic [2:0] lap_count_b,
  input wire logic [2:0] lap_count_c,
  input wire logic [2:0] capture_mask,
  input wire logic [5:0] now_seconds,
  input wire logic [6:0] now_centis
);

  // A stalled result beat stays offered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // The shown time is a legal clock value whenever a result is offered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (now_centis <= 7'd99) && (now_seconds <= 6'd59))
    else $error("time out of range");

  // Lap counts in an offered result never pass the number of lap slots.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (lap_count_a <= 3'd5) && (lap_count_b <= 3'd5) && (lap_count_c <= 3'd5))
    else $error("lap count above slot limit");

  // A lane that captured a lap has at least one lap on record.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!capture_mask[0] || (lap_count_a != 3'd0)) &&
                  (!capture_mask[1] || (lap_count_b != 3'd0)) &&
                  (!capture_mask[2] || (lap_count_c != 3'd0)))
    else $error("capture without lap count");

endmodule

bind three_lane_lap_timer tllt_checker u_tllt_checker (.*);

`default_nettype wire
